@@ hw/rtl/ssnw_pkg.sv @@
// Shared types, constants and glyph tables for the seven-segment number writer.
package ssnw_pkg;

  // Default sizes of the display buffer and request queue
  localparam int unsigned DIGIT_COUNT_DEFAULT = 8;
  localparam int unsigned FRAME_BYTES_DEFAULT = 10;
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

  // Binary-to-decimal converter sizing, fixed by the 32-bit value field
  localparam int unsigned VALUE_BITS  = 32;
  localparam int unsigned BCD_DIGITS  = 10;
  localparam int unsigned CONV_CNT_W  = $clog2(VALUE_BITS);

  // Glyph table slots
  localparam logic [4:0] GLYPH_ALPHA_BASE = 5'd10;
  localparam logic [4:0] GLYPH_U          = 5'd18;
  localparam logic [4:0] GLYPH_N          = 5'd19;
  localparam logic [4:0] GLYPH_DASH       = 5'd20;
  localparam logic [4:0] GLYPH_SPACE      = 5'd21;

  typedef enum logic [1:0] {
    FUNC_NUMBER = 2'd0,
    FUNC_CHAR   = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_BLANK  = 2'd3
  } func_e;

  // Classified command handed from front to back
  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_NUMBER = 2'd1,
    CMD_GLYPH  = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e     op;
    logic [3:0]  start_pos;
    logic [3:0]  end_pos;
    logic [31:0] value;
    logic [7:0]  glyph;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIZE,
    ST_WRITE,
    ST_EMIT
  } back_state_e;

  function automatic logic [7:0] glyph_rom(logic [4:0] idx);
    logic [7:0] g;
    case (idx)
      5'd0:    g = 8'hD7;
      5'd1:    g = 8'h50;
      5'd2:    g = 8'hB5;
      5'd3:    g = 8'hF1;
      5'd4:    g = 8'h72;
      5'd5:    g = 8'hE3;
      5'd6:    g = 8'hE7;
      5'd7:    g = 8'h51;
      5'd8:    g = 8'hF7;
      5'd9:    g = 8'hF3;
      5'd10:   g = 8'h77;
      5'd11:   g = 8'hE6;
      5'd12:   g = 8'hA4;
      5'd13:   g = 8'hF4;
      5'd14:   g = 8'hA7;
      5'd15:   g = 8'h27;
      5'd16:   g = 8'hC7;
      5'd17:   g = 8'h76;
      5'd18:   g = 8'hC4;
      5'd19:   g = 8'h64;
      5'd20:   g = 8'h20;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

  // ASCII to glyph; lower case folds to upper, unknown codes show zero
  function automatic logic [7:0] char_glyph(logic [7:0] c);
    logic [7:0] u;
    u = c;
    if (c inside {[8'h61:8'h7A]}) u = c - 8'd32;
    if (u inside {[8'h30:8'h39]}) return glyph_rom(5'(u - 8'h30));
    if (u inside {[8'h41:8'h48]}) return glyph_rom(GLYPH_ALPHA_BASE + 5'(u - 8'h41));
    if (u == 8'h55) return glyph_rom(GLYPH_U);
    if (u == 8'h4E) return glyph_rom(GLYPH_N);
    if (c == 8'h2D) return glyph_rom(GLYPH_DASH);
    if (c == 8'h20) return glyph_rom(GLYPH_SPACE);
    return glyph_rom(5'd0);
  endfunction

endpackage

@@ hw/rtl/ssnw_if.sv @@
// Request and frame-byte channel interfaces.
interface ssnw_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [3:0]  start_pos;
  logic [3:0]  end_pos;
  logic [31:0] value;
  logic [7:0]  char_code;

  modport source (output valid, func, start_pos, end_pos, value, char_code, input ready);
  modport sink   (input valid, func, start_pos, end_pos, value, char_code, output ready);
endinterface

interface ssnw_frame_if;
  logic       valid;
  logic       ready;
  logic [3:0] byte_index;
  logic [7:0] frame_byte;
  logic       last;

  modport source (output valid, byte_index, frame_byte, last, input ready);
  modport sink   (input valid, byte_index, frame_byte, last, output ready);
endinterface

@@ hw/rtl/ssnw_front.sv @@
// Front end: takes requests and classifies them into back-end commands.
module ssnw_front (
  ssnw_req_if.sink      req_i,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i,
  output ssnw_pkg::cmd_t cmd_o
);

  assign cmd_valid_o = req_i.valid;
  assign req_i.ready = cmd_ready_i;

  always_comb begin
    cmd_o.op        = ssnw_pkg::CMD_NONE;
    cmd_o.start_pos = req_i.start_pos;
    cmd_o.end_pos   = req_i.end_pos;
    cmd_o.value     = req_i.value;
    cmd_o.glyph     = 8'h00;
    case (ssnw_pkg::func_e'(req_i.func))
      ssnw_pkg::FUNC_NUMBER: begin
        // empty window leaves the digits alone
        cmd_o.op = (req_i.start_pos > req_i.end_pos) ? ssnw_pkg::CMD_NONE
                                                     : ssnw_pkg::CMD_NUMBER;
      end
      ssnw_pkg::FUNC_CHAR: begin
        cmd_o.op      = ssnw_pkg::CMD_GLYPH;
        cmd_o.end_pos = req_i.start_pos;
        cmd_o.glyph   = ssnw_pkg::char_glyph(req_i.char_code);
      end
      ssnw_pkg::FUNC_CLEAR: begin
        cmd_o.op = ssnw_pkg::CMD_CLEAR;
      end
      ssnw_pkg::FUNC_BLANK: begin
        // blank is a write of the empty glyph
        cmd_o.op      = ssnw_pkg::CMD_GLYPH;
        cmd_o.end_pos = req_i.start_pos;
      end
      default: begin
        cmd_o.op = ssnw_pkg::CMD_NONE;
      end
    endcase
  end

endmodule

@@ hw/rtl/ssnw_fifo.sv @@
// Small command queue between front and back end.
module ssnw_fifo #(
  parameter int unsigned Depth = ssnw_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  ssnw_pkg::cmd_t push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output ssnw_pkg::cmd_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ssnw_pkg::cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CntW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ hw/rtl/ssnw_back.sv @@
// Back end: decimal conversion, segment buffer update and frame output.
module ssnw_back #(
  parameter int unsigned DIGIT_COUNT = ssnw_pkg::DIGIT_COUNT_DEFAULT,
  parameter int unsigned FRAME_BYTES = ssnw_pkg::FRAME_BYTES_DEFAULT
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  input  ssnw_pkg::cmd_t cmd_i,
  ssnw_frame_if.source   frame_o
);

  localparam int unsigned BufIdxW   = $clog2(FRAME_BYTES);
  localparam int unsigned BcdW      = 4 * ssnw_pkg::BCD_DIGITS;
  localparam logic [3:0]  FrameLast = 4'(FRAME_BYTES - 1);

  ssnw_pkg::back_state_e state_q, state_d;

  ssnw_pkg::cmd_t cmd_q;
  logic [ssnw_pkg::VALUE_BITS-1:0] bin_q;
  logic [BcdW-1:0]                 bcd_q, bcd_adj;
  logic [ssnw_pkg::CONV_CNT_W-1:0] cnt_q;
  logic [3:0] pos_q, k_q, idx_q, top;
  logic [3:0] digits [ssnw_pkg::BCD_DIGITS];
  logic [3:0] digit_sel, ndig;
  logic [4:0] width, span;
  logic [7:0] wr_glyph;
  logic [7:0] buf_q [FRAME_BYTES];
  logic cmd_pop, wr_en, wr_ok, clr_en, emit_step;

  // Double-dabble correction and digit view
  always_comb begin
    for (int j = 0; j < ssnw_pkg::BCD_DIGITS; j++) begin
      digits[j] = bcd_q[4*j +: 4];
      bcd_adj[4*j +: 4] = (bcd_q[4*j +: 4] >= 4'd5) ? bcd_q[4*j +: 4] + 4'd3
                                                    : bcd_q[4*j +: 4];
    end
  end

  // Digit count of the value and index of the first digit shown
  always_comb begin
    ndig = '0;
    for (int j = 0; j < ssnw_pkg::BCD_DIGITS; j++) begin
      if (digits[j] != 4'd0) ndig = 4'(j + 1);
    end
    width = {1'b0, cmd_q.end_pos} - {1'b0, cmd_q.start_pos} + 5'd1;
    span  = (width > {1'b0, ndig}) ? width : {1'b0, ndig};
    top   = 4'(span - 5'd1);
  end

  assign digit_sel = (k_q < 4'(ssnw_pkg::BCD_DIGITS)) ? digits[k_q] : 4'd0;
  assign wr_glyph  = (cmd_q.op == ssnw_pkg::CMD_NUMBER) ?
                     ssnw_pkg::glyph_rom({1'b0, digit_sel}) : cmd_q.glyph;
  assign wr_ok     = (pos_q != 4'd0) && ({1'b0, pos_q} <= 5'(DIGIT_COUNT)) &&
                     ({1'b0, pos_q} < 5'(FRAME_BYTES));

  assign frame_o.byte_index = idx_q;
  assign frame_o.frame_byte = buf_q[idx_q[BufIdxW-1:0]];
  assign frame_o.last       = (idx_q == FrameLast);
  assign emit_step          = frame_o.valid && frame_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ssnw_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_ready_o   = 1'b0;
    cmd_pop       = 1'b0;
    wr_en         = 1'b0;
    clr_en        = 1'b0;
    frame_o.valid = 1'b0;
    case (state_q)
      ssnw_pkg::ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          cmd_pop = 1'b1;
          case (cmd_i.op)
            ssnw_pkg::CMD_NUMBER: state_d = ssnw_pkg::ST_CONV;
            ssnw_pkg::CMD_GLYPH:  state_d = ssnw_pkg::ST_WRITE;
            ssnw_pkg::CMD_CLEAR: begin
              clr_en  = 1'b1;
              state_d = ssnw_pkg::ST_EMIT;
            end
            default:              state_d = ssnw_pkg::ST_EMIT;
          endcase
        end
      end
      ssnw_pkg::ST_CONV: begin
        if (cnt_q == ssnw_pkg::CONV_CNT_W'(ssnw_pkg::VALUE_BITS - 1)) begin
          state_d = ssnw_pkg::ST_SIZE;
        end
      end
      ssnw_pkg::ST_SIZE: begin
        state_d = ssnw_pkg::ST_WRITE;
      end
      ssnw_pkg::ST_WRITE: begin
        wr_en = 1'b1;
        if (pos_q == cmd_q.end_pos) state_d = ssnw_pkg::ST_EMIT;
      end
      ssnw_pkg::ST_EMIT: begin
        frame_o.valid = 1'b1;
        if (frame_o.ready && frame_o.last) state_d = ssnw_pkg::ST_IDLE;
      end
      default: begin
        state_d = ssnw_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_pop) begin
      idx_q <= '0;
    end else if (emit_step) begin
      idx_q <= idx_q + 4'd1;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_pop) begin
      cmd_q <= cmd_i;
      bin_q <= cmd_i.value;
      bcd_q <= '0;
      cnt_q <= '0;
      pos_q <= cmd_i.start_pos;
    end
    if (state_q == ssnw_pkg::ST_CONV) begin
      bcd_q <= {bcd_adj[BcdW-2:0], bin_q[ssnw_pkg::VALUE_BITS-1]};
      bin_q <= {bin_q[ssnw_pkg::VALUE_BITS-2:0], 1'b0};
      cnt_q <= cnt_q + ssnw_pkg::CONV_CNT_W'(1);
    end
    if (state_q == ssnw_pkg::ST_SIZE) begin
      k_q <= top;
    end
    if (wr_en) begin
      pos_q <= pos_q + 4'd1;
      k_q   <= k_q - 4'd1;
    end
  end

  // Segment buffer: glyph high nibble in byte p, low bits in byte p-1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < FRAME_BYTES; j++) buf_q[j] <= 8'h00;
    end else begin
      for (int j = 0; j < FRAME_BYTES; j++) begin
        if (clr_en) begin
          if (j == 0) begin
            buf_q[j] <= {4'h0, buf_q[j][3:0]};
          end else if (j == FRAME_BYTES - 1) begin
            buf_q[j] <= {buf_q[j][7:4], 4'h0};
          end else begin
            buf_q[j] <= 8'h00;
          end
        end else if (wr_en && wr_ok) begin
          if ({1'b0, pos_q} == 5'(j)) begin
            buf_q[j][3:0] <= wr_glyph[7:4];
          end else if ({1'b0, pos_q} == 5'(j + 1)) begin
            buf_q[j][6:4] <= wr_glyph[2:0];
          end
        end
      end
    end
  end

endmodule

@@ hw/rtl/seven_segment_number_writer.sv @@
// Top level of the seven-segment number writer.
//
// Keeps the segment buffer of an eight-digit LCD and sends the whole buffer
// after every request. The request channel carries func, start_pos, end_pos,
// value and char_code; the frame channel returns FRAME_BYTES bytes per
// request, byte_index 0 first, last set on the final byte.
// A front stage classifies each request (glyph lookup, empty-window check)
// into a queue of QUEUE_DEPTH commands, so new requests are taken while the
// back end is still busy.
// Back end steps per request: pop the command, then
//  - number: shift-and-add-3 conversion of the 32 value bits (one bit per
//    cycle), a window sizing step, and a write for each position start..end;
//  - character or blank: a single write;
//  - clear or empty window: nothing more;
// followed by the FRAME_BYTES output bytes.
// Reset zeroes the buffer and empties the queue. When the receiver stalls,
// the current byte holds; once the queue is full request ready drops.
module seven_segment_number_writer #(
  parameter int unsigned DIGIT_COUNT = ssnw_pkg::DIGIT_COUNT_DEFAULT,
  parameter int unsigned FRAME_BYTES = ssnw_pkg::FRAME_BYTES_DEFAULT,
  parameter int unsigned QUEUE_DEPTH = ssnw_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ssnw_req_if.sink     req_i,
  ssnw_frame_if.source frame_o
);

  // front to queue
  logic           fq_valid, fq_ready;
  ssnw_pkg::cmd_t fq_cmd;
  // queue to back end
  logic           qb_valid, qb_ready;
  ssnw_pkg::cmd_t qb_cmd;

  ssnw_front u_front (
    .req_i       (req_i),
    .cmd_valid_o (fq_valid),
    .cmd_ready_i (fq_ready),
    .cmd_o       (fq_cmd)
  );

  ssnw_fifo #(
    .Depth (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_data_i  (fq_cmd),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_data_o   (qb_cmd)
  );

  ssnw_back #(
    .DIGIT_COUNT (DIGIT_COUNT),
    .FRAME_BYTES (FRAME_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (qb_valid),
    .cmd_ready_o (qb_ready),
    .cmd_i       (qb_cmd),
    .frame_o     (frame_o)
  );

endmodule

@@ tb/sv/ssnw_frame_checker.sv @@
// Checker for the seven-segment writer: mirrors the segment buffer, checks each frame byte.
module ssnw_frame_checker
  import ssnw_pkg::*;
#(
  parameter int unsigned DIGIT_COUNT = DIGIT_COUNT_DEFAULT,
  parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ssnw_req_if        req_i,
  ssnw_frame_if      frame_i,
  output int         fails_o,
  output int         bytes_due_o
);

  // glyphs by slot: digits, A..H, U, N, dash, space
  localparam logic [7:0] SEG_FONT [22] = '{
    8'hD7, 8'h50, 8'hB5, 8'hF1, 8'h72, 8'hE3, 8'hE7, 8'h51, 8'hF7, 8'hF3,
    8'h77, 8'hE6, 8'hA4, 8'hF4, 8'hA7, 8'h27, 8'hC7, 8'h76, 8'hC4, 8'h64,
    8'h20, 8'h00
  };

  typedef struct packed {
    logic [3:0] byte_index;
    logic [7:0] frame_byte;
    logic       last;
  } frame_beat_t;

  frame_beat_t due_bytes [$];
  logic [7:0]  lcd_image [FRAME_BYTES];
  int          mismatches = 0;
  int          beats_seen = 0;

  assign fails_o = mismatches;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at byte %0d: %s got 0x%0h want 0x%0h (t=%0t)",
             beats_seen, what, got, want, $time);
    mismatches++;
  endtask

  function automatic bit digit_slot_ok(int p);
    return p >= 1 && p <= int'(DIGIT_COUNT) && p < int'(FRAME_BYTES);
  endfunction

  // high nibble to byte p, low three bits to bits 6:4 of byte p-1
  function automatic void put_glyph(int p, logic [7:0] g);
    if (!digit_slot_ok(p)) return;
    lcd_image[p]     = {lcd_image[p][7:4], g[7:4]};
    lcd_image[p - 1] = {lcd_image[p - 1][7], g[2:0], lcd_image[p - 1][3:0]};
  endfunction

  function automatic logic [7:0] font_of_char(logic [7:0] c);
    logic [7:0] u;
    u = (c >= "a" && c <= "z") ? c - 8'd32 : c;
    if (u >= "0" && u <= "9") return SEG_FONT[u - "0"];
    if (u >= "A" && u <= "H") return SEG_FONT[GLYPH_ALPHA_BASE + (u - "A")];
    if (u == "U") return SEG_FONT[GLYPH_U];
    if (u == "N") return SEG_FONT[GLYPH_N];
    if (c == "-") return SEG_FONT[GLYPH_DASH];
    if (c == " ") return SEG_FONT[GLYPH_SPACE];
    return SEG_FONT[0];
  endfunction

  // right-aligned, zero padded; an over-long value keeps its leading digits
  function automatic void put_number(int s, int e, logic [31:0] v);
    int          dec [16];
    logic [31:0] t;
    int          n, w, msd, i;
    if (s > e) return;
    w = e - s + 1;
    for (i = s; i <= e; i++) put_glyph(i, SEG_FONT[GLYPH_SPACE]);
    t = v;
    for (i = 0; i < 16; i++) begin
      dec[i] = int'(t % 10);
      t = t / 10;
    end
    n = 0;
    t = v;
    while (t != 0) begin
      n++;
      t = t / 10;
    end
    msd = (w > n ? w : n) - 1;
    for (i = 0; i < w; i++)
      put_glyph(s + i, SEG_FONT[(msd - i) < 16 ? dec[msd - i] : 0]);
  endfunction

  function automatic void apply_request(func_e f, int s, int e, logic [31:0] v,
                                        logic [7:0] c);
    logic [7:0] keep_lo, keep_hi;
    int         i;
    case (f)
      FUNC_NUMBER: put_number(s, e, v);
      FUNC_CHAR:   put_glyph(s, font_of_char(c));
      FUNC_CLEAR: begin
        keep_lo = lcd_image[0] & 8'h0F;
        keep_hi = lcd_image[FRAME_BYTES - 1] & 8'hF0;
        for (i = 0; i < int'(FRAME_BYTES); i++) lcd_image[i] = '0;
        lcd_image[0] = keep_lo;
        lcd_image[FRAME_BYTES - 1] = lcd_image[FRAME_BYTES - 1] | keep_hi;
      end
      default: begin
        if (digit_slot_ok(s)) begin
          lcd_image[s]     = lcd_image[s] & 8'hF0;
          lcd_image[s - 1] = lcd_image[s - 1] & 8'h8F;
        end
      end
    endcase
    for (i = 0; i < int'(FRAME_BYTES); i++)
      due_bytes.push_back('{byte_index: 4'(i), frame_byte: lcd_image[i],
                            last: (i == int'(FRAME_BYTES) - 1)});
  endfunction

  task automatic check_beat();
    frame_beat_t want;
    if (due_bytes.size() == 0) begin
      report_mismatch("frame byte with nothing due, index", int'(frame_i.byte_index), -1);
    end else begin
      want = due_bytes.pop_front();
      if (frame_i.byte_index !== want.byte_index)
        report_mismatch("byte_index", int'(frame_i.byte_index), int'(want.byte_index));
      if (frame_i.frame_byte !== want.frame_byte)
        report_mismatch("frame_byte", int'(frame_i.frame_byte), int'(want.frame_byte));
      if (frame_i.last !== want.last)
        report_mismatch("last", int'(frame_i.last), int'(want.last));
    end
    beats_seen++;
  endtask

  // bytes out are taken before the request in, so a byte never meets its own request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      due_bytes.delete();
      for (int i = 0; i < int'(FRAME_BYTES); i++) lcd_image[i] = '0;
    end else begin
      if (frame_i.valid && frame_i.ready) check_beat();
      if (req_i.valid && req_i.ready)
        apply_request(func_e'(req_i.func), int'(req_i.start_pos), int'(req_i.end_pos),
                      req_i.value, req_i.char_code);
    end
    bytes_due_o <= due_bytes.size();
  end

endmodule

@@ tb/sv/tb_seven_segment_number_writer.sv @@
// Testbench top for the seven-segment number writer: request stimulus, frame stalls, verdict.
module tb_seven_segment_number_writer;
  import ssnw_pkg::*;

  // Longest stretch with no handshake on either channel in a correct run:
  // the pop, 32 conversion steps, sizing and up to 16 writes of a full number
  // request before its first byte, plus the longest receiver stall and sender
  // gap. Far below this figure.
  localparam int STUCK_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 105;
  // final stretch of the run with both sides at full rate
  localparam int CALM_ITEMS   = 25;
  // cycles to watch for stray bytes once everything has arrived
  localparam int DRAIN_CYCLES = 64;

  logic  clk_i  = 1'b0;
  logic  rst_ni = 1'b0;
  bit    calm_tail = 1'b0;
  int    fails;
  int    bytes_due;
  int    stuck_cycles = 0;
  // well-formed characters, both cases; anything else is thrown in at random
  string char_pool = "0123456789ABCDEFGHUNabcdefghun- ";

  ssnw_req_if   req_if ();
  ssnw_frame_if frame_if ();

  seven_segment_number_writer dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .frame_o (frame_if)
  );

  ssnw_frame_checker u_frame_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .frame_i     (frame_if),
    .fails_o     (fails),
    .bytes_due_o (bytes_due)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Watchdog: any accepted request or frame byte clears the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (frame_if.valid && frame_if.ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Frame receiver: ready runs of random length, some long, broken by stalls;
  // no stalls once the calm tail starts.
  initial begin
    frame_if.ready <= 1'b1;
    forever begin
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(40, 120)) @(posedge clk_i);
      else repeat ($urandom_range(1, 20)) @(posedge clk_i);
      if (!calm_tail) begin
        frame_if.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        frame_if.ready <= 1'b1;
      end
    end
  end

  // Random sender gap after a request; valid drops only in the accept step,
  // so it is never lowered and raised in one step.
  task automatic pace();
    if (!calm_tail && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  // Present one request and hold it until the block takes it.
  // Called in a rising-edge step; returns after acceptance and any sender gap.
  task automatic push_request(input func_e f, input logic [3:0] s, input logic [3:0] e,
                              input logic [31:0] v, input logic [7:0] c);
    req_if.valid     <= 1'b1;
    req_if.func      <= f;
    req_if.start_pos <= s;
    req_if.end_pos   <= e;
    req_if.value     <= v;
    req_if.char_code <= c;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    pace();
  endtask

  // Mostly well-formed requests: windows inside the display, start not past
  // end for numbers, characters from the supported set. Now and then any
  // 4-bit position and any character code.
  task automatic random_request();
    func_e       f;
    logic [3:0]  s, e, t;
    logic [31:0] v;
    logic [7:0]  c;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: f = FUNC_NUMBER;
      4, 5, 6:    f = FUNC_CHAR;
      7:          f = FUNC_CLEAR;
      default:    f = FUNC_BLANK;
    endcase
    if ($urandom_range(0, 7) == 0) begin
      s = 4'($urandom);
      e = 4'($urandom);
    end else begin
      s = 4'($urandom_range(1, DIGIT_COUNT_DEFAULT));
      e = 4'($urandom_range(1, DIGIT_COUNT_DEFAULT));
      if (f == FUNC_NUMBER && s > e) begin
        t = s;
        s = e;
        e = t;
      end
    end
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: v = $urandom_range(0, 999);
      2: begin
        // a power of ten or one below it: digit-count boundaries
        v = 32'd1;
        repeat ($urandom_range(0, 9)) v = v * 10;
        if ($urandom_range(0, 1) == 1) v = v - 1;
      end
      default: v = $urandom >> $urandom_range(0, 31);
    endcase
    if ($urandom_range(0, 4) == 0) c = 8'($urandom);
    else c = char_pool[$urandom_range(0, char_pool.len() - 1)];
    push_request(f, s, e, v, c);
  endtask

  initial begin
    req_if.valid     <= 1'b0;
    req_if.func      <= FUNC_NUMBER;
    req_if.start_pos <= '0;
    req_if.end_pos   <= '0;
    req_if.value     <= '0;
    req_if.char_code <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed part ---
    // numbers: zero over the full window, all-ones value longer than the window
    push_request(FUNC_NUMBER, 4'd1, 4'd8, 32'd0, 8'h00);
    push_request(FUNC_NUMBER, 4'd1, 4'd8, 32'hFFFF_FFFF, 8'hFF);
    // short value, zero padded in a middle window; single-digit windows
    push_request(FUNC_NUMBER, 4'd3, 4'd6, 32'd7, 8'h00);
    push_request(FUNC_NUMBER, 4'd1, 4'd1, 32'd9, 8'h00);
    push_request(FUNC_NUMBER, 4'd8, 4'd8, 32'd1234, 8'h00);
    // start after end leaves the digits alone
    push_request(FUNC_NUMBER, 4'd6, 4'd3, 32'd123, 8'h00);
    // windows reaching past the digits: out-of-range slots skipped
    push_request(FUNC_NUMBER, 4'd0, 4'd9, 32'd123456789, 8'h00);
    push_request(FUNC_NUMBER, 4'd0, 4'd15, 32'hFFFF_FFFF, 8'h00);
    push_request(FUNC_NUMBER, 4'd15, 4'd15, 32'd5, 8'h00);
    // characters: digit, letters in both cases, U, N, dash, space
    push_request(FUNC_CHAR, 4'd1, 4'd0, 32'd0, "0");
    push_request(FUNC_CHAR, 4'd2, 4'd0, 32'd0, "a");
    push_request(FUNC_CHAR, 4'd3, 4'd0, 32'd0, "H");
    push_request(FUNC_CHAR, 4'd4, 4'd0, 32'd0, "u");
    push_request(FUNC_CHAR, 4'd5, 4'd0, 32'd0, "N");
    push_request(FUNC_CHAR, 4'd6, 4'd0, 32'd0, "-");
    push_request(FUNC_CHAR, 4'd7, 4'd0, 32'd0, " ");
    // unsupported codes fall back to the zero glyph
    push_request(FUNC_CHAR, 4'd8, 4'd0, 32'd0, "Z");
    push_request(FUNC_CHAR, 4'd8, 4'd15, 32'hFFFF_FFFF, 8'hFF);
    // character at an out-of-range position
    push_request(FUNC_CHAR, 4'd0, 4'd0, 32'd0, "5");
    push_request(FUNC_CHAR, 4'd15, 4'd0, 32'd0, "9");
    // blanking: inside, at position 0 and above the digits
    push_request(FUNC_BLANK, 4'd3, 4'd0, 32'd0, 8'h00);
    push_request(FUNC_BLANK, 4'd0, 4'd0, 32'd0, 8'h00);
    push_request(FUNC_BLANK, 4'd9, 4'd0, 32'd0, 8'h00);
    // clear with every other field at its maximum, then refill one digit
    push_request(FUNC_CLEAR, 4'd15, 4'd15, 32'hFFFF_FFFF, 8'hFF);
    push_request(FUNC_CHAR, 4'd1, 4'd0, 32'd0, "e");

    // Hold the sender until the whole backlog of frames has come back.
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (bytes_due != 0);

    // --- random part ---
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm_tail = (n >= RANDOM_ITEMS - CALM_ITEMS);
      random_request();
    end
    req_if.valid <= 1'b0;

    do @(posedge clk_i); while (bytes_due != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fails == 0 && bytes_due == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
